[hdl/srg_pkg.sv]
// ----------------------------------------------------------------------------
// srg_pkg
// Shared types and constants for the setpoint ramp generator.
// ----------------------------------------------------------------------------
package srg_pkg;

  localparam int unsigned ValW    = 32;
  localparam int unsigned StepW   = 33;
  localparam int unsigned PeriodW = 8;
  localparam int unsigned IterW   = 5;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SET  = 1'b1;

  localparam logic [IterW-1:0] LAST_ITER = IterW'(ValW - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_FIN  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  typedef struct packed {
    logic set_target;
    logic div_step;
    logic div_finish;
    logic tick_exec;
  } cmd_t;

  typedef struct packed {
    logic period_zero;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

[hdl/srg_ctrl.sv]
// ----------------------------------------------------------------------------
// srg_ctrl
// Sequencer: accepts items, steps the serial divider and issues ticks.
// ----------------------------------------------------------------------------
module srg_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_opcode,
  output logic          in_ready,
  input  srg_pkg::sts_t sts,
  output srg_pkg::cmd_t cmd
);

  srg_pkg::state_t state_r, state_nxt;
  logic            accept;

  assign in_ready = (state_r == srg_pkg::ST_IDLE);
  assign accept   = in_valid & in_ready;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    case (state_r)
      srg_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_opcode == srg_pkg::OP_SET) begin
            cmd.set_target = 1'b1;
            if (!sts.period_zero) state_nxt = srg_pkg::ST_DIV;
          end else begin
            state_nxt = srg_pkg::ST_EMIT;
          end
        end
      end
      srg_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = srg_pkg::ST_FIN;
      end
      srg_pkg::ST_FIN: begin
        cmd.div_finish = 1'b1;
        state_nxt      = srg_pkg::ST_IDLE;
      end
      srg_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.tick_exec = 1'b1;
          state_nxt     = srg_pkg::ST_IDLE;
        end
      end
      default: state_nxt = srg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srg_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hdl/srg_dp.sv]
// ----------------------------------------------------------------------------
// srg_dp
// Datapath: ramp state, restoring divider for the step, output register.
// ----------------------------------------------------------------------------
module srg_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic [srg_pkg::PeriodW-1:0]         cfg_ramp_period,
  input  logic signed [srg_pkg::ValW-1:0]     in_target_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [srg_pkg::ValW-1:0]     out_ramp_output,
  input  srg_pkg::cmd_t                       cmd,
  output srg_pkg::sts_t                       sts
);

  logic [srg_pkg::PeriodW-1:0]        period_r;
  logic signed [srg_pkg::ValW-1:0]    target_r;
  logic signed [srg_pkg::ValW-1:0]    level_r;
  logic signed [srg_pkg::StepW-1:0]   step_r;
  logic [srg_pkg::PeriodW-1:0]        tick_r;
  logic [srg_pkg::ValW-1:0]           dvd_r;
  logic [srg_pkg::PeriodW-1:0]        rem_r;
  logic [srg_pkg::IterW-1:0]          iter_r;
  logic                               neg_r;
  logic                               out_valid_r;
  logic signed [srg_pkg::ValW-1:0]    out_r;

  logic signed [srg_pkg::StepW-1:0]   diff;
  logic [srg_pkg::StepW-1:0]          diff_abs;
  logic [srg_pkg::PeriodW:0]          rem_sh;
  logic [srg_pkg::PeriodW:0]          rem_sub;
  logic                               q_bit;
  logic signed [srg_pkg::StepW:0]     sum;
  logic signed [srg_pkg::ValW-1:0]    sum_sat;
  logic signed [srg_pkg::ValW-1:0]    tick_val;
  logic                               in_ramp;

  assign diff     = {in_target_value[srg_pkg::ValW-1], in_target_value}
                  - {target_r[srg_pkg::ValW-1], target_r};
  assign diff_abs = diff[srg_pkg::StepW-1] ? (-diff) : diff;

  assign rem_sh  = {rem_r, dvd_r[srg_pkg::ValW-1]};
  assign rem_sub = rem_sh - {1'b0, period_r};
  assign q_bit   = (rem_sh >= {1'b0, period_r});

  assign sum = {{2{level_r[srg_pkg::ValW-1]}}, level_r}
             + {step_r[srg_pkg::StepW-1], step_r};

  always_comb begin
    if (sum[srg_pkg::StepW:srg_pkg::ValW-1] == '0 ||
        sum[srg_pkg::StepW:srg_pkg::ValW-1] == '1) begin
      sum_sat = sum[srg_pkg::ValW-1:0];
    end else if (sum[srg_pkg::StepW]) begin
      sum_sat = {1'b1, {(srg_pkg::ValW-1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(srg_pkg::ValW-1){1'b1}}};
    end
  end

  assign in_ramp  = (tick_r < period_r);
  assign tick_val = in_ramp ? sum_sat : target_r;

  assign sts.period_zero = (period_r == '0);
  assign sts.div_last    = (iter_r == srg_pkg::LAST_ITER);
  assign sts.out_free    = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_ramp_output = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= '0;
      target_r <= '0;
      level_r  <= '0;
      step_r   <= '0;
      tick_r   <= '0;
      iter_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) period_r <= cfg_ramp_period;

      if (cmd.set_target) begin
        target_r <= in_target_value;
        tick_r   <= '0;
        iter_r   <= '0;
        if (period_r == '0) step_r <= '0;
      end

      if (cmd.div_step) iter_r <= iter_r + 1'b1;

      if (cmd.div_finish) begin
        step_r <= neg_r ? -$signed({1'b0, dvd_r}) : $signed({1'b0, dvd_r});
      end

      // advance the ramp or snap to target
      if (cmd.tick_exec) begin
        level_r <= tick_val;
        if (in_ramp) tick_r <= tick_r + 1'b1;
      end

      if (cmd.tick_exec) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_target) begin
      dvd_r <= diff_abs[srg_pkg::ValW-1:0];
      rem_r <= '0;
      neg_r <= diff[srg_pkg::StepW-1];
    end else if (cmd.div_step) begin
      rem_r <= q_bit ? rem_sub[srg_pkg::PeriodW-1:0] : rem_sh[srg_pkg::PeriodW-1:0];
      dvd_r <= {dvd_r[srg_pkg::ValW-2:0], q_bit};
    end
    if (cmd.tick_exec) out_r <= tick_val;
  end

endmodule

[hdl/setpoint_ramp_generator_top.sv]
// Setpoint ramp generator. A set-target item (opcode 1) stores a new signed
// Q16.16 target and derives a per-tick step with a serial restoring divider
// that produces one quotient bit per cycle, so it occupies the block through
// accept, 32 divide steps and sign fix-up, or only through accept when the
// period is zero; it returns no item. A tick item (opcode 0) waits in emit
// for the output register to drain and returns the saturated output.
// A new item is accepted while a finished result still waits in the output
// register. Write ramp_period only while the block is idle.
// ----------------------------------------------------------------------------
// setpoint_ramp_generator_top
// Top level: sequencer plus ramp datapath behind valid/ready channels.
// ----------------------------------------------------------------------------
module setpoint_ramp_generator_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [srg_pkg::PeriodW-1:0]     cfg_ramp_period,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_opcode,
  input  logic signed [srg_pkg::ValW-1:0] in_target_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [srg_pkg::ValW-1:0] out_ramp_output
);

  srg_pkg::cmd_t cmd;
  srg_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  srg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  srg_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ramp_period (cfg_ramp_period),
    .in_target_value (in_target_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_ramp_output (out_ramp_output),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

[test/setpoint_ramp_generator_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setpoint_ramp_generator_top_test
// Self-checking bench for the setpoint ramp generator. A directed table covers
// the reset level, zero period, full-scale targets and saturation in both
// directions. Random set-target and tick items follow over several ramp
// periods, with random gaps on the input and stalls on the output. Every tick
// result is checked against a row's given value or an in-bench ramp predictor.
// ----------------------------------------------------------------------------
module setpoint_ramp_generator_top_test;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned PHASE_COUNT    = 8;
  localparam int unsigned PHASE_ITEMS    = 100;
  localparam int unsigned DIR_ROWS       = 25;

  localparam logic signed [srg_pkg::ValW-1:0] Q_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [srg_pkg::ValW-1:0] Q_MIN  = 32'sh8000_0000;
  localparam logic signed [srg_pkg::ValW-1:0] Q_ZERO = 32'sh0000_0000;
  localparam logic signed [srg_pkg::ValW-1:0] Q_NEG1 = 32'shFFFF_FFFF;

  typedef struct {
    logic                              op;
    logic signed [srg_pkg::ValW-1:0]   level;
    bit                                wr_period;
    logic [srg_pkg::PeriodW-1:0]       period;
    bit                                typed;
    logic signed [srg_pkg::ValW-1:0]   want;
  } stim_row_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [srg_pkg::PeriodW-1:0]       cfg_ramp_period = '0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic                              in_opcode = srg_pkg::OP_TICK;
  logic signed [srg_pkg::ValW-1:0]   in_target_value = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic signed [srg_pkg::ValW-1:0]   out_ramp_output;

  logic [srg_pkg::PeriodW-1:0]       period_q = '0;
  logic signed [srg_pkg::ValW-1:0]   start_q = '0;
  logic signed [srg_pkg::ValW-1:0]   target_q = '0;
  logic signed [srg_pkg::StepW-1:0]  step_q = '0;
  logic [srg_pkg::PeriodW-1:0]       ticks_q = '0;
  logic signed [srg_pkg::ValW-1:0]   level_q = '0;

  logic signed [srg_pkg::ValW-1:0]   ramp_levels_due [$];
  int unsigned                       fail_count = 0;
  int unsigned                       idle_cycles = 0;
  int unsigned                       stall_left = 0;
  bit                                src_eager = 1'b0;
  bit                                sink_eager = 1'b0;

  stim_row_t dir_rows [DIR_ROWS] = '{
    '{srg_pkg::OP_TICK, Q_ZERO, 1'b0, 8'd0,   1'b1, Q_ZERO},
    '{srg_pkg::OP_SET,  Q_MAX,  1'b0, 8'd0,   1'b0, Q_ZERO},
    '{srg_pkg::OP_TICK, Q_ZERO, 1'b0, 8'd0,   1'b1, Q_MAX},
    '{srg_pkg::OP_SET,  Q_MIN,  1'b0, 8'd0,   1'b0, Q_ZERO},
    '{srg_pkg::OP_TICK, Q_ZERO, 1'b0, 8'd0,   1'b1, Q_MIN},
    '{srg_pkg::OP_TICK, Q_MAX,  1'b0, 8'd0,   1'b1, Q_MIN},
    '{srg_pkg::OP_SET,  Q_MAX,  1'b1, 8'd1,   1'b0, Q_ZERO},
    '{srg_pkg::OP_TICK, Q_ZERO, 1'b0, 8'd0,   1'b0, Q_ZERO},
    '{srg_pkg::OP_TICK, Q_ZERO, 1'b0, 8'd0,   1'b0, Q_ZERO},
    '{srg_pkg::OP_SET,  Q_MIN,  1'b0, 8'd0,   1'b0, Q_ZERO},
    '{srg_pkg::OP_SET,  Q_MAX,  1'b0, 8'd0,   1'b0, Q_ZERO},
    '{srg_pkg::OP_TICK, Q_ZERO, 1'b0, 8'd0,   1'b0, Q_ZERO},
    '{srg_pkg::OP_SET,  Q_MIN,  1'b0, 8'd0,   1'b0, Q_ZERO},
    '{srg_pkg::OP_TICK, Q_ZERO, 1'b0, 8'd0,   1'b0, Q_ZERO},
    '{srg_pkg::OP_SET,  Q_MAX,  1'b0, 8'd0,   1'b0, Q_ZERO},
    '{srg_pkg::OP_SET,  Q_MIN,  1'b0, 8'd0,   1'b0, Q_ZERO},
    '{srg_pkg::OP_TICK, Q_ZERO, 1'b0, 8'd0,   1'b0, Q_ZERO},
    '{srg_pkg::OP_SET,  32'sh00FF_0000, 1'b1, 8'd255, 1'b0, Q_ZERO},
    '{srg_pkg::OP_TICK, Q_ZERO, 1'b0, 8'd0,   1'b0, Q_ZERO},
    '{srg_pkg::OP_TICK, Q_ZERO, 1'b0, 8'd0,   1'b0, Q_ZERO},
    '{srg_pkg::OP_SET,  Q_ZERO, 1'b0, 8'd0,   1'b0, Q_ZERO},
    '{srg_pkg::OP_TICK, Q_ZERO, 1'b0, 8'd0,   1'b0, Q_ZERO},
    '{srg_pkg::OP_SET,  Q_NEG1, 1'b1, 8'd0,   1'b0, Q_ZERO},
    '{srg_pkg::OP_TICK, Q_ZERO, 1'b0, 8'd0,   1'b1, Q_NEG1},
    '{srg_pkg::OP_TICK, Q_NEG1, 1'b0, 8'd0,   1'b1, Q_NEG1}
  };

  setpoint_ramp_generator_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_ramp_period (cfg_ramp_period),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_target_value (in_target_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_ramp_output (out_ramp_output)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  function automatic logic signed [srg_pkg::ValW-1:0] random_level();
    logic signed [srg_pkg::ValW-1:0] v;
    case ($urandom_range(0, 9))
      0: v = Q_MAX;
      1: v = Q_MIN;
      2: v = Q_ZERO;
      3, 4, 5: begin
        v = $urandom_range(0, 32'h00FF_FFFF);
        if ($urandom_range(0, 1) != 0) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic bit ramp_advance(input logic op,
                                      input logic signed [srg_pkg::ValW-1:0] level,
                                      output logic signed [srg_pkg::ValW-1:0] result);
    longint diff;
    longint sum;
    result = level_q;
    if (op == srg_pkg::OP_SET) begin
      start_q  = target_q;
      target_q = level;
      diff     = longint'(target_q) - longint'(start_q);
      step_q   = (period_q != 0) ? srg_pkg::StepW'(diff / longint'(period_q)) : '0;
      ticks_q  = '0;
      return 1'b0;
    end
    if (ticks_q < period_q) begin
      sum = longint'(level_q) + longint'(step_q);
      if (sum > longint'(Q_MAX)) level_q = Q_MAX;
      else if (sum < longint'(Q_MIN)) level_q = Q_MIN;
      else level_q = srg_pkg::ValW'(sum);
      ticks_q = ticks_q + 1'b1;
    end else begin
      level_q = target_q;
    end
    result = level_q;
    return 1'b1;
  endfunction

  task automatic drain_results();
    in_valid <= 1'b0;
    while (ramp_levels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_period(input logic [srg_pkg::PeriodW-1:0] p);
    drain_results();
    cfg_valid       <= 1'b1;
    cfg_ramp_period <= p;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    period_q = p;
  endtask

  task automatic send_item(input logic op, input logic signed [srg_pkg::ValW-1:0] level,
                           input bit typed, input logic signed [srg_pkg::ValW-1:0] want);
    int unsigned                     gap;
    bit                              has_level;
    logic signed [srg_pkg::ValW-1:0] level_due;
    gap = src_eager ? 0 : gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_target_value <= level;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    has_level = ramp_advance(op, level, level_due);
    if (has_level) ramp_levels_due.push_back(typed ? want : level_due);
  endtask

  always @(posedge clk) begin
    int unsigned n;
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      n = gap_len();
      if (sink_eager || n == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready  <= 1'b0;
        stall_left <= n - 1;
      end
    end
  end

  always @(posedge clk) begin
    logic signed [srg_pkg::ValW-1:0] due;
    if (rst_n && out_valid && out_ready) begin
      if (ramp_levels_due.size() == 0) begin
        $error("ramp_output with none due: got %0d", out_ramp_output);
        fail_count++;
      end else begin
        due = ramp_levels_due.pop_front();
        if (out_ramp_output !== due) begin
          $error("ramp_output mismatch: expected %0d, got %0d", due, out_ramp_output);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $error("no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("[setpoint_ramp_generator_top] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [srg_pkg::PeriodW-1:0] p;
    int unsigned                 set_odds;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].wr_period) write_period(dir_rows[i].period);
      send_item(dir_rows[i].op, dir_rows[i].level, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0: p = 8'd1;
        1: p = srg_pkg::PeriodW'($urandom_range(2, 8));
        2: p = 8'd255;
        3: p = 8'd0;
        4: p = srg_pkg::PeriodW'($urandom_range(3, 20));
        default: p = srg_pkg::PeriodW'($urandom_range(0, 255));
      endcase
      write_period(p);
      src_eager  = (ph % 3 == 1);
      sink_eager = (ph % 3 == 2);
      set_odds   = (period_q > 16) ? 60 : 4;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 49) == 0) drain_results();
        if ($urandom_range(0, set_odds - 1) == 0) begin
          send_item(srg_pkg::OP_SET, random_level(), 1'b0, Q_ZERO);
        end else begin
          send_item(srg_pkg::OP_TICK, $urandom, 1'b0, Q_ZERO);
        end
      end
    end

    drain_results();
    if (fail_count == 0) begin
      $display("[setpoint_ramp_generator_top] OK");
    end else begin
      $display("[setpoint_ramp_generator_top] ERROR");
    end
    $finish;
  end

endmodule

[setpoint_ramp_generator_top.f]
hdl/srg_pkg.sv
hdl/srg_ctrl.sv
hdl/srg_dp.sv
hdl/setpoint_ramp_generator_top.sv
test/setpoint_ramp_generator_top_test.sv
